[design/aff2d_pkg.sv]
package aff2d_pkg;

  // Angle reduction runs on Q2.30 values held in 35 bits
  localparam int WRAP_W = 35;
  localparam int ATAN_ENTRIES = 30;

  localparam logic signed [WRAP_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [WRAP_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [WRAP_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [31:0]       CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic signed [63:0] RND_Q30 = 64'sd536870912;
  localparam logic signed [63:0] RND_Q16 = 64'sd32768;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // atan(2^-i), Q2.30
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef logic signed [31:0] word_t;

  // Fields that ride along the pipeline untouched
  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t scale_x;
    word_t scale_y;
    word_t origin_x;
    word_t origin_y;
  } side_t;

  // One rotator stage
  typedef struct packed {
    logic  vld;
    logic  neg;
    word_t x;
    word_t y;
    word_t z;
    side_t side;
  } rot_t;

  typedef struct packed {
    logic  vld;
    word_t m00;
    word_t m01;
    word_t m10;
    word_t m11;
    word_t trans_x;
    word_t trans_y;
    word_t trans_z;
  } res_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[design/aff2d_item_if.sv]
interface aff2d_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] angle;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;

  modport source (
    output valid, pos_x, pos_y, pos_z, angle, scale_x, scale_y, origin_x, origin_y,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, angle, scale_x, scale_y, origin_x, origin_y,
    output ready
  );
endinterface

[design/aff2d_result_if.sv]
interface aff2d_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (
    output valid, m00, m01, m10, m11, trans_x, trans_y, trans_z,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m10, m11, trans_x, trans_y, trans_z,
    output ready
  );
endinterface

[design/aff2d_wrap.sv]
// Angle wrap to [0, 2pi), shift to (-pi, pi], fold to [-pi/2, pi/2].
module aff2d_wrap (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vld,
  input  aff2d_pkg::word_t       angle,
  input  aff2d_pkg::side_t       side,
  output aff2d_pkg::rot_t        q
);

  typedef struct packed {
    logic                                  vld;
    logic signed [aff2d_pkg::WRAP_W-1:0]   a;
    aff2d_pkg::side_t                      side;
  } wstage_t;

  wstage_t s1, s2, s3;
  wstage_t s1_next, s2_next, s3_next;
  aff2d_pkg::rot_t q_next;
  logic signed [aff2d_pkg::WRAP_W-1:0] w;
  logic signed [aff2d_pkg::WRAP_W-1:0] zf;

  // angle * 4 moves Q4.28 to Q2.30
  assign w = {angle[31], angle, 2'b00};

  always_comb begin
    s1_next.vld  = vld;
    s1_next.side = side;
    if (w < 0) begin
      s1_next.a = w + aff2d_pkg::TWO_PI_Q30;
    end else if (w >= aff2d_pkg::TWO_PI_Q30) begin
      s1_next.a = w - aff2d_pkg::TWO_PI_Q30;
    end else begin
      s1_next.a = w;
    end

    s2_next = s1;
    if (s1.a < 0) begin
      s2_next.a = s1.a + aff2d_pkg::TWO_PI_Q30;
    end

    s3_next = s2;
    if (s2.a > aff2d_pkg::PI_Q30) begin
      s3_next.a = s2.a - aff2d_pkg::TWO_PI_Q30;
    end

    // folding by pi negates both sine and cosine
    q_next.vld  = s3.vld;
    q_next.side = s3.side;
    q_next.x    = aff2d_pkg::CORDIC_GAIN_Q30;
    q_next.y    = '0;
    if (s3.a > aff2d_pkg::HALF_PI_Q30) begin
      zf         = s3.a - aff2d_pkg::PI_Q30;
      q_next.neg = 1'b1;
    end else if (s3.a < -aff2d_pkg::HALF_PI_Q30) begin
      zf         = s3.a + aff2d_pkg::PI_Q30;
      q_next.neg = 1'b1;
    end else begin
      zf         = s3.a;
      q_next.neg = 1'b0;
    end
    q_next.z = zf[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
      s2.vld <= 1'b0;
      s3.vld <= 1'b0;
      q.vld  <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      q  <= q_next;
    end
  end

endmodule

[design/aff2d_cordic_cell.sv]
// One CORDIC rotation step, registered.
module aff2d_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  aff2d_pkg::rot_t d,
  output aff2d_pkg::rot_t q
);

  localparam logic signed [31:0] ATAN = aff2d_pkg::ATAN_Q30[SHIFT];

  aff2d_pkg::rot_t q_next;
  logic signed [31:0] dx, dy;

  assign dx = $signed(d.y) >>> SHIFT;
  assign dy = $signed(d.x) >>> SHIFT;

  always_comb begin
    q_next = d;
    if (!d.z[31]) begin
      q_next.x = $signed(d.x) - dx;
      q_next.y = $signed(d.y) + dy;
      q_next.z = $signed(d.z) - ATAN;
    end else begin
      q_next.x = $signed(d.x) + dx;
      q_next.y = $signed(d.y) - dy;
      q_next.z = $signed(d.z) + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

[design/aff2d_matrix.sv]
// Scale by sin/cos, saturate, then apply the pivot offset.
module aff2d_matrix (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  aff2d_pkg::rot_t d,
  output aff2d_pkg::res_t q
);

  typedef logic signed [63:0] prod_t;

  typedef struct packed {
    logic                vld;
    aff2d_pkg::word_t    c;
    aff2d_pkg::word_t    s;
    aff2d_pkg::side_t    side;
  } trig_st_t;

  typedef struct packed {
    logic                vld;
    prod_t               c_sx;
    prod_t               s_sy;
    prod_t               s_sx;
    prod_t               c_sy;
    aff2d_pkg::side_t    side;
  } prod_st_t;

  typedef struct packed {
    logic                vld;
    aff2d_pkg::word_t    m00;
    aff2d_pkg::word_t    m01;
    aff2d_pkg::word_t    m10;
    aff2d_pkg::word_t    m11;
    aff2d_pkg::side_t    side;
  } mat_st_t;

  typedef struct packed {
    logic                vld;
    aff2d_pkg::word_t    m00;
    aff2d_pkg::word_t    m01;
    aff2d_pkg::word_t    m10;
    aff2d_pkg::word_t    m11;
    prod_t               p00;
    prod_t               p01;
    prod_t               p10;
    prod_t               p11;
    aff2d_pkg::word_t    pos_x;
    aff2d_pkg::word_t    pos_y;
    aff2d_pkg::word_t    pos_z;
  } off_st_t;

  trig_st_t t, t_next;
  prod_st_t p, p_next;
  mat_st_t  m, m_next;
  off_st_t  o, o_next;
  aff2d_pkg::res_t q_next;

  prod_t r_c_sx, r_s_sy, r_s_sx, r_c_sy;
  prod_t r00, r01, r10, r11;

  always_comb begin
    t_next.vld  = d.vld;
    t_next.side = d.side;
    t_next.c    = d.neg ? -$signed(d.x) : $signed(d.x);
    t_next.s    = d.neg ? -$signed(d.y) : $signed(d.y);

    p_next.vld  = t.vld;
    p_next.side = t.side;
    p_next.c_sx = $signed(t.c) * $signed(t.side.scale_x);
    p_next.s_sy = $signed(t.s) * $signed(t.side.scale_y);
    p_next.s_sx = $signed(t.s) * $signed(t.side.scale_x);
    p_next.c_sy = $signed(t.c) * $signed(t.side.scale_y);

    // round Q2.30 * Q16.16 back to Q16.16
    r_c_sx = ($signed(p.c_sx) + aff2d_pkg::RND_Q30) >>> 30;
    r_s_sy = ($signed(p.s_sy) + aff2d_pkg::RND_Q30) >>> 30;
    r_s_sx = ($signed(p.s_sx) + aff2d_pkg::RND_Q30) >>> 30;
    r_c_sy = ($signed(p.c_sy) + aff2d_pkg::RND_Q30) >>> 30;
    m_next.vld  = p.vld;
    m_next.side = p.side;
    m_next.m00  = aff2d_pkg::sat32(r_c_sx);
    m_next.m01  = aff2d_pkg::sat32(-r_s_sy);
    m_next.m10  = aff2d_pkg::sat32(r_s_sx);
    m_next.m11  = aff2d_pkg::sat32(r_c_sy);

    o_next.vld   = m.vld;
    o_next.m00   = m.m00;
    o_next.m01   = m.m01;
    o_next.m10   = m.m10;
    o_next.m11   = m.m11;
    o_next.pos_x = m.side.pos_x;
    o_next.pos_y = m.side.pos_y;
    o_next.pos_z = m.side.pos_z;
    o_next.p00   = $signed(m.m00) * $signed(m.side.origin_x);
    o_next.p01   = $signed(m.m01) * $signed(m.side.origin_y);
    o_next.p10   = $signed(m.m10) * $signed(m.side.origin_x);
    o_next.p11   = $signed(m.m11) * $signed(m.side.origin_y);

    r00 = ($signed(o.p00) + aff2d_pkg::RND_Q16) >>> 16;
    r01 = ($signed(o.p01) + aff2d_pkg::RND_Q16) >>> 16;
    r10 = ($signed(o.p10) + aff2d_pkg::RND_Q16) >>> 16;
    r11 = ($signed(o.p11) + aff2d_pkg::RND_Q16) >>> 16;
    q_next.vld     = o.vld;
    q_next.m00     = o.m00;
    q_next.m01     = o.m01;
    q_next.m10     = o.m10;
    q_next.m11     = o.m11;
    q_next.trans_x = aff2d_pkg::sat32(64'($signed(o.pos_x)) - (r00 + r01));
    q_next.trans_y = aff2d_pkg::sat32(64'($signed(o.pos_y)) - (r10 + r11));
    q_next.trans_z = o.pos_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t.vld <= 1'b0;
      p.vld <= 1'b0;
      m.vld <= 1'b0;
      o.vld <= 1'b0;
      q.vld <= 1'b0;
    end else if (en) begin
      t <= t_next;
      p <= p_next;
      m <= m_next;
      o <= o_next;
      q <= q_next;
    end
  end

endmodule

[design/affine_transform_2d_core.sv]
// 2D affine transform composer: translate(pos) * rotZ(angle) * scale * translate(-origin).
// item (sink): pos_x/y/z, scale_x/y, origin_x/y in Q16.16, angle in Q4.28 radians.
// result (source): m00, m01, m10, m11, trans_x, trans_y (Q16.16, saturated) and
//   trans_z = pos_z. Exactly one result per input transfer, in order.
// Throughput: one item per cycle unless a stall freezes the chain. Items flow through
//   a chain of registered stages: 4 angle-wrap stages, one CORDIC cell per iteration
//   (at most 30), 5 multiply / round / offset stages and the output register.
// Stall: a held result sits in the output register. The chain behind it keeps
//   moving as long as the stage feeding the output register is empty; once a
//   result is parked there too, the whole chain and item.ready freeze until the
//   receiver takes a transfer. Nothing is dropped or duplicated.
// Reset (rst, synchronous, active high): clears all stage valid bits, so the
//   pipeline is empty and result.valid is low on the next cycle.
module affine_transform_2d_core #(
  parameter int TRIG_ITERATIONS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  aff2d_item_if.sink            item,
  aff2d_result_if.source        result
);

  // Number of rotator cells; the arctangent table has 30 entries
  localparam int NCELLS = (TRIG_ITERATIONS < aff2d_pkg::ATAN_ENTRIES) ?
                          TRIG_ITERATIONS : aff2d_pkg::ATAN_ENTRIES;

  aff2d_pkg::side_t side_in;
  aff2d_pkg::rot_t  chain [NCELLS+1];
  aff2d_pkg::res_t  pre;      // last matrix stage, feeds the output register
  aff2d_pkg::res_t  out_reg;

  logic en_out;   // output register may load
  logic en;       // rest of the chain may advance

  assign en_out = !out_reg.vld || result.ready;
  // A bubble in front of the output register can be overwritten freely
  assign en     = en_out || !pre.vld;

  assign item.ready = en;

  assign side_in.pos_x    = item.pos_x;
  assign side_in.pos_y    = item.pos_y;
  assign side_in.pos_z    = item.pos_z;
  assign side_in.scale_x  = item.scale_x;
  assign side_in.scale_y  = item.scale_y;
  assign side_in.origin_x = item.origin_x;
  assign side_in.origin_y = item.origin_y;

  // Angle reduction; the accepted transfer loads its first stage
  aff2d_wrap u_wrap (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vld   (item.valid),
    .angle (item.angle),
    .side  (side_in),
    .q     (chain[0])
  );

  // Rotator: one cell per iteration (at most 30), cell i shifts by i
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    aff2d_cordic_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  aff2d_matrix u_matrix (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (chain[NCELLS]),
    .q   (pre)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.vld <= 1'b0;
    end else if (en_out) begin
      out_reg <= pre;
    end
  end

  assign result.valid   = out_reg.vld;
  assign result.m00     = out_reg.m00;
  assign result.m01     = out_reg.m01;
  assign result.m10     = out_reg.m10;
  assign result.m11     = out_reg.m11;
  assign result.trans_x = out_reg.trans_x;
  assign result.trans_y = out_reg.trans_y;
  assign result.trans_z = out_reg.trans_z;

endmodule

[design/aff2d_checker.sv]
module aff2d_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [223:0] out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // nothing held at the output: the input side must be open
  a_idle_ready: assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // receiver taking a transfer never blocks the input side
  a_drain_ready: assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("input blocked while output drains");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind affine_transform_2d_core aff2d_checker u_aff2d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  ({result.m00, result.m01, result.m10, result.m11,
               result.trans_x, result.trans_y, result.trans_z})
);

[sim/affine_transform_2d_checker.sv]
module affine_transform_2d_checker #(
  parameter int TRIG_ITERATIONS = 20
) (
  input  logic    clk,
  input  logic    rst,
  aff2d_item_if   item,
  aff2d_result_if result,
  output int      fail_count,
  output int      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef aff2d_pkg::word_t word_t;

  localparam longint TWO_PI   = 64'sd6746518852;
  localparam longint PI       = 64'sd3373259426;
  localparam longint HALF_PI  = 64'sd1686629713;
  localparam longint GAIN     = 64'sd652032874;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam longint HALF_Q16 = 64'sd32768;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam int     ATAN_COUNT = 30;

  // atan(2^-i) in Q2.30
  localparam longint ARCTAN [ATAN_COUNT] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
    'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
    'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
    'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
    'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
    'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
  };

  typedef struct packed {
    word_t m00;
    word_t m01;
    word_t m10;
    word_t m11;
    word_t trans_x;
    word_t trans_y;
    word_t trans_z;
  } xform_t;

  xform_t expected_xforms[$];
  xform_t want;
  xform_t got;

  function automatic word_t clamp_word(longint v);
    if (v > WORD_MAX) begin
      return 32'sh7FFFFFFF;
    end
    if (v < WORD_MIN) begin
      return 32'sh80000000;
    end
    return word_t'(v);
  endfunction

  // wrap to [-pi/2, pi/2], fold sign, then CORDIC rotate
  function automatic void sin_cos_q30(input word_t ang, output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit flip;
    int i;
    z = (longint'(ang) * 4) % TWO_PI;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    if (z < 0) begin
      z += TWO_PI;
    end
    if (z > PI) begin
      z -= TWO_PI;
    end
    if (z > HALF_PI) begin
      z -= PI;
      flip = 1'b1;
    end else if (z < -HALF_PI) begin
      z += PI;
      flip = 1'b1;
    end
    for (i = 0; i < TRIG_ITERATIONS && i < ATAN_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint trig_scale(longint t, word_t sc);
    return (t * longint'(sc) + HALF_Q30) >>> 30;
  endfunction

  function automatic longint q16_product(word_t a, word_t b);
    return (longint'(a) * longint'(b) + HALF_Q16) >>> 16;
  endfunction

  function automatic xform_t compose_xform(word_t px, word_t py, word_t pz, word_t ang,
                                           word_t sx, word_t sy, word_t ox, word_t oy);
    xform_t r;
    longint c;
    longint s;
    sin_cos_q30(ang, c, s);
    r.m00 = clamp_word(trig_scale(c, sx));
    r.m01 = clamp_word(-trig_scale(s, sy));
    r.m10 = clamp_word(trig_scale(s, sx));
    r.m11 = clamp_word(trig_scale(c, sy));
    r.trans_x = clamp_word(longint'(px) - (q16_product(r.m00, ox) + q16_product(r.m01, oy)));
    r.trans_y = clamp_word(longint'(py) - (q16_product(r.m10, ox) + q16_product(r.m11, oy)));
    r.trans_z = pz;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, word_t seen, word_t wanted);
    if (seen !== wanted) begin
      report_mismatch($sformatf("%s got %h want %h", name, seen, wanted));
    end
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item.valid && item.ready) begin
        expected_xforms.push_back(compose_xform(item.pos_x, item.pos_y, item.pos_z,
                                                item.angle, item.scale_x, item.scale_y,
                                                item.origin_x, item.origin_y));
      end
      if (result.valid && result.ready) begin
        got = '{result.m00, result.m01, result.m10, result.m11,
                result.trans_x, result.trans_y, result.trans_z};
        if (expected_xforms.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          want = expected_xforms.pop_front();
          check_field("m00", got.m00, want.m00);
          check_field("m01", got.m01, want.m01);
          check_field("m10", got.m10, want.m10);
          check_field("m11", got.m11, want.m11);
          check_field("trans_x", got.trans_x, want.trans_x);
          check_field("trans_y", got.trans_y, want.trans_y);
          check_field("trans_z", got.trans_z, want.trans_z);
        end
      end
      outstanding <= expected_xforms.size();
    end
  end

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef aff2d_pkg::word_t word_t;

  localparam int TRIG_ITERATIONS = 20;
  // input transfer to result.valid, per the pipeline depth of the core
  localparam int LATENCY = TRIG_ITERATIONS + 10;
  localparam int RANDOM_ITEMS = 500;
  // worst case per item adds the longest gap, the longest stall and the
  // latency; this is several times that for ~525 items
  localparam int CYCLE_LIMIT = 200000;

  // Q16.16 and Q4.28 landmarks used by the directed part
  localparam word_t ONE      = 32'sd65536;
  localparam word_t WORD_MAX = 32'sh7FFFFFFF;
  localparam word_t WORD_MIN = 32'sh80000000;
  localparam word_t HALF_PI  = 32'sd421657428;   // largest angle that is not folded
  localparam word_t PI       = 32'sd843314856;   // largest angle below pi after wrap
  localparam word_t TWO_PI   = 32'sd1686629713;  // wraps to exactly zero

  typedef struct {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t angle;
    word_t scale_x;
    word_t scale_y;
    word_t origin_x;
    word_t origin_y;
  } sprite_t;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   sent = 0;
  int   taken = 0;

  aff2d_item_if   item_bus();
  aff2d_result_if result_bus();

  always #5 clk = ~clk;

  affine_transform_2d_core #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus)
  );

  // Watches both channels, predicts every result and counts mismatches.
  affine_transform_2d_checker #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  function automatic sprite_t make_sprite(word_t px, word_t py, word_t pz, word_t ang,
                                          word_t sx, word_t sy, word_t ox, word_t oy);
    sprite_t sp;
    sp = '{px, py, pz, ang, sx, sy, ox, oy};
    return sp;
  endfunction

  // uniform in [-span, span]
  function automatic word_t rand_span(int span);
    return word_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Scenes a renderer would send: moderate scales and pivots, any angle.
  // The rest is raw 32-bit noise that drives every bit and hits saturation.
  function automatic sprite_t rand_sprite();
    sprite_t sp;
    if ($urandom_range(0, 9) < 7) begin
      sp.pos_x    = rand_span(1 << 28);
      sp.pos_y    = rand_span(1 << 28);
      sp.pos_z    = $urandom;
      sp.angle    = $urandom;
      sp.scale_x  = rand_span(1 << 19);          // +/- 8.0
      sp.scale_y  = rand_span(1 << 19);
      sp.origin_x = rand_span(1 << 24);          // +/- 256.0
      sp.origin_y = rand_span(1 << 24);
    end else begin
      sp = '{$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
    end
    return sp;
  endfunction

  // Present one item and hold it until the core takes the transfer.
  // The gap before it is drawn per item; some stretches run with no gaps
  // so back-to-back transfers get exercised too.
  task automatic send_sprite(sprite_t sp);
    int gap;
    gap = ((sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid    <= 1'b1;
    item_bus.pos_x    <= sp.pos_x;
    item_bus.pos_y    <= sp.pos_y;
    item_bus.pos_z    <= sp.pos_z;
    item_bus.angle    <= sp.angle;
    item_bus.scale_x  <= sp.scale_x;
    item_bus.scale_y  <= sp.scale_y;
    item_bus.origin_x <= sp.origin_x;
    item_bus.origin_y <= sp.origin_y;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    sent++;
  endtask

  // Hard stop: anything still running here counts as a hang.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  // Result side: stall a random number of cycles, then accept one transfer.
  // Ready may go high long before valid, so stalls land on every phase.
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = ((taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    sprite_t directed[$];

    // every input known from the first edge on
    rst                <= 1'b1;
    item_bus.valid     <= 1'b0;
    item_bus.pos_x     <= '0;
    item_bus.pos_y     <= '0;
    item_bus.pos_z     <= '0;
    item_bus.angle     <= '0;
    item_bus.scale_x   <= '0;
    item_bus.scale_y   <= '0;
    item_bus.origin_x  <= '0;
    item_bus.origin_y  <= '0;
    result_bus.ready   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // identity, then quadrant landmarks with a pivot
    directed.push_back(make_sprite(0, 0, 0, 0, ONE, ONE, 0, 0));
    directed.push_back(make_sprite(ONE, 2 * ONE, 3 * ONE, HALF_PI, ONE, ONE,
                                   10 * ONE, 20 * ONE));
    // one step past half pi: folded by pi with both trig signs flipped
    directed.push_back(make_sprite(0, 0, 0, HALF_PI + 1, 2 * ONE, ONE, ONE, -ONE));
    directed.push_back(make_sprite(0, 0, 0, -HALF_PI, ONE, 2 * ONE, ONE, ONE));
    directed.push_back(make_sprite(0, 0, 0, -HALF_PI - 1, ONE, ONE, -ONE, ONE));
    // either side of pi: just below stays, just above wraps negative
    directed.push_back(make_sprite(5 * ONE, -5 * ONE, 0, PI, 2 * ONE, 2 * ONE, ONE, ONE));
    directed.push_back(make_sprite(5 * ONE, -5 * ONE, 0, PI + 1, 2 * ONE, 2 * ONE, ONE, ONE));
    directed.push_back(make_sprite(0, 0, 0, -PI - 1, ONE, ONE, ONE, ONE));
    // exact full turn in both directions wraps to zero
    directed.push_back(make_sprite(0, 0, 0, TWO_PI, ONE, ONE, ONE, ONE));
    directed.push_back(make_sprite(0, 0, 0, -TWO_PI, ONE, ONE, ONE, ONE));
    // angle word extremes, more than a full turn out
    directed.push_back(make_sprite(0, 0, WORD_MAX, WORD_MAX, ONE, ONE, ONE, ONE));
    directed.push_back(make_sprite(0, 0, WORD_MIN, WORD_MIN, ONE, ONE, ONE, ONE));
    // zero and negative scale go straight through the formulas
    directed.push_back(make_sprite(ONE, ONE, ONE, HALF_PI / 2, 0, 0, 7 * ONE, 7 * ONE));
    directed.push_back(make_sprite(ONE, ONE, ONE, HALF_PI / 3, -3 * ONE, -ONE / 2,
                                   ONE, 2 * ONE));
    // matrix entries saturate at both rails
    directed.push_back(make_sprite(0, 0, 0, 0, WORD_MAX, WORD_MAX, 0, 0));
    directed.push_back(make_sprite(0, 0, 0, 0, WORD_MIN, WORD_MIN, 0, 0));
    directed.push_back(make_sprite(0, 0, 0, HALF_PI, WORD_MAX, WORD_MIN, 0, 0));
    // translations saturate: large entries times large pivots plus far positions
    directed.push_back(make_sprite(WORD_MAX, WORD_MIN, 0, 0, WORD_MAX, WORD_MAX,
                                   WORD_MIN, WORD_MIN));
    directed.push_back(make_sprite(WORD_MIN, WORD_MAX, 0, 0, WORD_MAX, WORD_MAX,
                                   WORD_MAX, WORD_MAX));
    directed.push_back(make_sprite(WORD_MAX, WORD_MAX, WORD_MAX, PI / 2, WORD_MIN, WORD_MIN,
                                   WORD_MAX, WORD_MIN));
    // all fields at the negative rail, then all at the positive rail
    directed.push_back(make_sprite(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                                   WORD_MIN, WORD_MIN, WORD_MIN));
    directed.push_back(make_sprite(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MAX, WORD_MAX, WORD_MAX));
    directed.push_back(make_sprite(-1, -1, -1, -1, -1, -1, -1, -1));

    foreach (directed[i]) send_sprite(directed[i]);
    repeat (RANDOM_ITEMS) send_sprite(rand_sprite());
    item_bus.valid <= 1'b0;

    // let the count pick up the last transfer, drain, then give any stray
    // result time to show up
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
